// ===== hdl/cubed_sphere_face_xyz_transform_core_macros.svh =====
// Assertion macros for the cubed-sphere face transform core.
// Included by the files that carry concurrent assertions; depends on nothing.
`ifndef CUBED_SPHERE_FACE_XYZ_TRANSFORM_CORE_MACROS_SVH
`define CUBED_SPHERE_FACE_XYZ_TRANSFORM_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CSFT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CSFT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/csft_pkg.sv =====
// Shared types, widths and constants of the cubed-sphere face transform core.
// Used by every module of the block; depends on nothing.
`default_nettype none

package csft_pkg;

    // Fixed-point format of angles and vector components.
    localparam int FRAC_BITS = 16;
    localparam int Q30_SHIFT = 30 - FRAC_BITS;

    // Port field widths.
    localparam int IN_W  = 18;
    localparam int XYZ_W = 18;
    localparam int ANG_W = 19;

    // Internal widths: CORDIC x/y lane, CORDIC angle, sine/cosine and
    // product, square-root and divider datapath, quotient.
    localparam int LW = 54;
    localparam int ZW = 21;
    localparam int CW = 20;
    localparam int SW = 36;
    localparam int QW = FRAC_BITS + 1;

    // Operands of atan2 are scaled up by this many bits before vectoring.
    localparam int ATAN_PRESCALE = 32;

    // Codes of the action and face fields.
    localparam logic       ACT_FWD = 1'b0;
    localparam logic       ACT_INV = 1'b1;
    localparam logic [2:0] FACE_PX = 3'd0;
    localparam logic [2:0] FACE_NX = 3'd1;
    localparam logic [2:0] FACE_PY = 3'd2;
    localparam logic [2:0] FACE_NY = 3'd3;
    localparam logic [2:0] FACE_PZ = 3'd4;
    localparam logic [2:0] FACE_NZ = 3'd5;

    // Q30 constants, brought down to FRAC_BITS by a floor shift.
    localparam logic [31:0] PI_Q30   = 32'hC90F_DAA2;
    localparam logic [31:0] GAIN_Q30 = 32'd652032874;

    localparam logic signed [ZW-1:0] ONE_Q  = ZW'(1) <<< FRAC_BITS;
    localparam logic signed [ZW-1:0] PI_Q   = ZW'(PI_Q30 >> Q30_SHIFT);
    localparam logic signed [ZW-1:0] GAIN_Q = ZW'(GAIN_Q30 >> Q30_SHIFT);

    // atan(2^-i) in Q30, truncated.
    localparam logic [31:0] ATAN_Q30 [32] = '{
        32'd843314856, 32'd497837829, 32'd263043836, 32'd133525158,
        32'd67021686,  32'd33543515,  32'd16775850,  32'd8388437,
        32'd4194282,   32'd2097149,   32'd1048575,   32'd524287,
        32'd262143,    32'd131071,    32'd65535,     32'd32767,
        32'd16383,     32'd8191,      32'd4095,      32'd2047,
        32'd1023,      32'd511,       32'd255,       32'd127,
        32'd63,        32'd31,        32'd15,        32'd7,
        32'd3,         32'd1,         32'd0,         32'd0
    };

    // Elementary CORDIC angle of one stage in the working format.
    function automatic logic signed [ZW-1:0] atan_f(input logic [4:0] idx);
        return ZW'(ATAN_Q30[idx] >> Q30_SHIFT);
    endfunction

    // Control flags that travel with each item.
    typedef struct packed {
        logic fwd;
        logic err;
        logic zero_a;
        logic zero_b;
    } t_ctl;

    // Item payload carried through the norm and divide stages.
    typedef struct packed {
        t_ctl                    ctl;
        logic signed [CW-1:0]    v0;
        logic signed [CW-1:0]    v1;
        logic signed [CW-1:0]    v2;
        logic signed [ANG_W-1:0] alpha;
        logic signed [ANG_W-1:0] beta;
    } t_pay;

endpackage

`default_nettype wire

// ===== hdl/csft_cordic_stage.sv =====
// One registered CORDIC micro-rotation, shared by rotation and vectoring mode.
// Depends on csft_pkg for widths and the elementary angle table.
`default_nettype none

module csft_cordic_stage #(
    parameter int IDX = 0
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_en,
    input  wire logic                           i_rot,
    input  wire logic signed [csft_pkg::LW-1:0] i_x,
    input  wire logic signed [csft_pkg::LW-1:0] i_y,
    input  wire logic signed [csft_pkg::ZW-1:0] i_z,
    output logic signed [csft_pkg::LW-1:0]      o_x,
    output logic signed [csft_pkg::LW-1:0]      o_y,
    output logic signed [csft_pkg::ZW-1:0]      o_z
);

    localparam logic signed [csft_pkg::ZW-1:0] ANG = csft_pkg::atan_f(5'(IDX));

    logic                              pos;
    logic signed [csft_pkg::LW-1:0]    dx;
    logic signed [csft_pkg::LW-1:0]    dy;
    logic signed [csft_pkg::LW-1:0]    n_x;
    logic signed [csft_pkg::LW-1:0]    n_y;
    logic signed [csft_pkg::ZW-1:0]    n_z;
    logic signed [csft_pkg::LW-1:0]    r_x;
    logic signed [csft_pkg::LW-1:0]    r_y;
    logic signed [csft_pkg::ZW-1:0]    r_z;

    // Rotation steers by the residual angle, vectoring by the sign of y.
    // Both share one update: a positive step subtracts the angle.
    always_comb begin
        pos = i_rot ? !i_z[csft_pkg::ZW-1] : i_y[csft_pkg::LW-1];
        dx  = i_y >>> IDX;
        dy  = i_x >>> IDX;
        n_x = pos ? i_x - dx : i_x + dx;
        n_y = pos ? i_y + dy : i_y - dy;
        n_z = pos ? i_z - ANG : i_z + ANG;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;

endmodule

`default_nettype wire

// ===== hdl/csft_sqrt_stage.sv =====
// One registered step of the bit-pair integer square root.
// Depends on csft_pkg for the datapath width.
`default_nettype none

module csft_sqrt_stage #(
    parameter int BIT_POS = 0
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_en,
    input  wire logic [csft_pkg::SW-1:0] i_n,
    input  wire logic [csft_pkg::SW-1:0] i_r,
    output logic [csft_pkg::SW-1:0]      o_n,
    output logic [csft_pkg::SW-1:0]      o_r
);

    localparam logic [csft_pkg::SW-1:0] BIT = csft_pkg::SW'(1) << BIT_POS;

    logic [csft_pkg::SW-1:0] trial;
    logic                    ge;
    logic [csft_pkg::SW-1:0] n_n;
    logic [csft_pkg::SW-1:0] n_r;
    logic [csft_pkg::SW-1:0] r_n;
    logic [csft_pkg::SW-1:0] r_r;

    // Subtract the trial value when it fits and set this root bit.
    always_comb begin
        trial = i_r + BIT;
        ge    = (i_n >= trial);
        n_n   = ge ? i_n - trial : i_n;
        n_r   = ge ? (i_r >> 1) + BIT : (i_r >> 1);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_n <= n_n;
            r_r <= n_r;
        end
    end

    assign o_n = r_n;
    assign o_r = r_r;

endmodule

`default_nettype wire

// ===== hdl/csft_div_stage.sv =====
// One registered step of restoring division, giving one quotient bit.
// Depends on csft_pkg for the datapath and quotient widths.
`default_nettype none

module csft_div_stage #(
    parameter int QBIT = 0
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_en,
    input  wire logic [csft_pkg::SW-1:0] i_div,
    input  wire logic [csft_pkg::SW-1:0] i_rem,
    input  wire logic [csft_pkg::QW-1:0] i_q,
    output logic [csft_pkg::SW-1:0]      o_rem,
    output logic [csft_pkg::QW-1:0]      o_q
);

    localparam logic [csft_pkg::QW-1:0] QMASK = csft_pkg::QW'(1) << QBIT;

    logic [csft_pkg::SW-1:0] shifted;
    logic                    ge;
    logic [csft_pkg::SW-1:0] n_rem;
    logic [csft_pkg::QW-1:0] n_q;
    logic [csft_pkg::SW-1:0] r_rem;
    logic [csft_pkg::QW-1:0] r_q;

    // Compare against the divisor aligned to this quotient bit.
    always_comb begin
        shifted = i_div << QBIT;
        ge      = (i_rem >= shifted);
        n_rem   = ge ? i_rem - shifted : i_rem;
        n_q     = ge ? (i_q | QMASK) : i_q;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= n_rem;
            r_q   <= n_q;
        end
    end

    assign o_rem = r_rem;
    assign o_q   = r_q;

endmodule

`default_nettype wire

// ===== hdl/cubed_sphere_face_xyz_transform_core.sv =====
// Cubed-sphere face transform: face angles to unit vector and back.
// Uses csft_pkg, csft_cordic_stage, csft_sqrt_stage, csft_div_stage and the macros header.
//
// Usage: one item in on the input channel (i_in_valid / o_in_ready) gives one
// result on the output channel (o_out_valid / i_out_ready). Action 0 turns the
// angles of a face into a unit vector (sine/cosine CORDIC, products, face
// placement, integer square root, three dividers); action 1 turns a vector into
// the two face angles (two atan2 CORDIC lanes). Face codes 6 and 7 give zeros
// and set o_error.
// The pipeline has one prepare stage, the CORDIC stages (18 by default), three
// product/norm stages, 18 square-root stages, one numerator stage, 17 divider
// stages and the output register. One item is taken per cycle while the output
// is not stalled; every stage is a register stage.
// Reset clears all valid bits; data registers are not reset.
// When the receiver holds i_out_ready low with a result waiting, the whole
// pipeline freezes and o_in_ready drops; no item is lost or repeated.
`default_nettype none

`include "cubed_sphere_face_xyz_transform_core_macros.svh"

module cubed_sphere_face_xyz_transform_core #(
    parameter int CORDIC_STAGES = 18
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_in_valid,
    output logic                                      o_in_ready,
    input  wire logic                                 i_action,
    input  wire logic [2:0]                           i_face,
    input  wire logic signed [csft_pkg::IN_W-1:0]     i_angle_a,
    input  wire logic signed [csft_pkg::IN_W-1:0]     i_angle_b,
    input  wire logic signed [csft_pkg::IN_W-1:0]     i_comp_x,
    input  wire logic signed [csft_pkg::IN_W-1:0]     i_comp_y,
    input  wire logic signed [csft_pkg::IN_W-1:0]     i_comp_z,
    output logic                                      o_out_valid,
    input  wire logic                                 i_out_ready,
    output logic signed [csft_pkg::XYZ_W-1:0]         o_out_x,
    output logic signed [csft_pkg::XYZ_W-1:0]         o_out_y,
    output logic signed [csft_pkg::XYZ_W-1:0]         o_out_z,
    output logic signed [csft_pkg::ANG_W-1:0]         o_out_alpha,
    output logic signed [csft_pkg::ANG_W-1:0]         o_out_beta,
    output logic                                      o_error
);

    localparam int LW  = csft_pkg::LW;
    localparam int ZW  = csft_pkg::ZW;
    localparam int CW  = csft_pkg::CW;
    localparam int SW  = csft_pkg::SW;
    localparam int QW  = csft_pkg::QW;
    localparam int AW  = csft_pkg::ANG_W;
    localparam int XW  = csft_pkg::XYZ_W;
    localparam int EW  = csft_pkg::IN_W + 1;
    localparam int SQ_STAGES = SW / 2;
    localparam int LAT = CORDIC_STAGES + SQ_STAGES + QW + 6;

    // ------------------------------------------------------------------
    // Handshake and valid pipeline
    // ------------------------------------------------------------------
    logic           en;
    logic           in_xfer;
    logic [LAT-1:0] r_vld;

    assign en         = !r_vld[LAT-1] || i_out_ready;
    assign in_xfer    = i_in_valid && en;
    assign o_in_ready = en;
    assign o_out_valid = r_vld[LAT-1];

    // Valid bits shift along with the data of each stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], in_xfer};
        end
    end

    // ------------------------------------------------------------------
    // Prepare stage: clamp angles, pick atan2 operands, fold left half-plane
    // ------------------------------------------------------------------
    csft_pkg::t_ctl          n_p_ctl;
    logic signed [ZW-1:0]    ang_a;
    logic signed [ZW-1:0]    ang_b;
    logic signed [EW-1:0]    ex;
    logic signed [EW-1:0]    ey;
    logic signed [EW-1:0]    ez;
    logic signed [EW-1:0]    ya_raw;
    logic signed [EW-1:0]    xa_raw;
    logic signed [EW-1:0]    yb_raw;
    logic signed [EW-1:0]    xb_raw;
    logic signed [EW-1:0]    ya_f;
    logic signed [EW-1:0]    xa_f;
    logic signed [EW-1:0]    yb_f;
    logic signed [EW-1:0]    xb_f;
    logic signed [ZW-1:0]    za_f;
    logic signed [ZW-1:0]    zb_f;
    logic signed [LW-1:0]    n_p_ax;
    logic signed [LW-1:0]    n_p_ay;
    logic signed [ZW-1:0]    n_p_az;
    logic signed [LW-1:0]    n_p_bx;
    logic signed [LW-1:0]    n_p_by;
    logic signed [ZW-1:0]    n_p_bz;
    logic signed [LW-1:0]    r_p_ax;
    logic signed [LW-1:0]    r_p_ay;
    logic signed [ZW-1:0]    r_p_az;
    logic signed [LW-1:0]    r_p_bx;
    logic signed [LW-1:0]    r_p_by;
    logic signed [ZW-1:0]    r_p_bz;
    csft_pkg::t_ctl          r_p_ctl;

    always_comb begin
        // Forward angles saturate to one radian either way.
        ang_a = ZW'(i_angle_a);
        ang_b = ZW'(i_angle_b);
        if (ang_a > csft_pkg::ONE_Q) begin
            ang_a = csft_pkg::ONE_Q;
        end else if (ang_a < -csft_pkg::ONE_Q) begin
            ang_a = -csft_pkg::ONE_Q;
        end
        if (ang_b > csft_pkg::ONE_Q) begin
            ang_b = csft_pkg::ONE_Q;
        end else if (ang_b < -csft_pkg::ONE_Q) begin
            ang_b = -csft_pkg::ONE_Q;
        end

        // Face-specific (y, x) pairs of the two atan2 evaluations.
        ex = EW'(i_comp_x);
        ey = EW'(i_comp_y);
        ez = EW'(i_comp_z);
        case (i_face)
            csft_pkg::FACE_PX: begin
                ya_raw = ey;  xa_raw = ex;  yb_raw = ez;  xb_raw = ex;
            end
            csft_pkg::FACE_NX: begin
                ya_raw = -ey; xa_raw = -ex; yb_raw = ez;  xb_raw = -ex;
            end
            csft_pkg::FACE_PY: begin
                ya_raw = -ex; xa_raw = ey;  yb_raw = ez;  xb_raw = ey;
            end
            csft_pkg::FACE_NY: begin
                ya_raw = ex;  xa_raw = -ey; yb_raw = ez;  xb_raw = -ey;
            end
            csft_pkg::FACE_PZ: begin
                ya_raw = ey;  xa_raw = ez;  yb_raw = -ex; xb_raw = ez;
            end
            default: begin
                ya_raw = ey;  xa_raw = -ez; yb_raw = ex;  xb_raw = -ez;
            end
        endcase

        // A negative x is mirrored into the right half-plane with a pi offset.
        if (xa_raw[EW-1]) begin
            za_f = ya_raw[EW-1] ? -csft_pkg::PI_Q : csft_pkg::PI_Q;
            xa_f = -xa_raw;
            ya_f = -ya_raw;
        end else begin
            za_f = '0;
            xa_f = xa_raw;
            ya_f = ya_raw;
        end
        if (xb_raw[EW-1]) begin
            zb_f = yb_raw[EW-1] ? -csft_pkg::PI_Q : csft_pkg::PI_Q;
            xb_f = -xb_raw;
            yb_f = -yb_raw;
        end else begin
            zb_f = '0;
            xb_f = xb_raw;
            yb_f = yb_raw;
        end

        n_p_ctl.fwd    = (i_action == csft_pkg::ACT_FWD);
        n_p_ctl.err    = (i_face > csft_pkg::FACE_NZ);
        n_p_ctl.zero_a = (xa_raw == '0) && (ya_raw == '0);
        n_p_ctl.zero_b = (xb_raw == '0) && (yb_raw == '0);

        // Lane start values for the chosen mode.
        if (n_p_ctl.fwd) begin
            n_p_ax = LW'(csft_pkg::GAIN_Q);
            n_p_ay = '0;
            n_p_az = ang_a;
            n_p_bx = LW'(csft_pkg::GAIN_Q);
            n_p_by = '0;
            n_p_bz = ang_b;
        end else begin
            n_p_ax = LW'(xa_f) <<< csft_pkg::ATAN_PRESCALE;
            n_p_ay = LW'(ya_f) <<< csft_pkg::ATAN_PRESCALE;
            n_p_az = za_f;
            n_p_bx = LW'(xb_f) <<< csft_pkg::ATAN_PRESCALE;
            n_p_by = LW'(yb_f) <<< csft_pkg::ATAN_PRESCALE;
            n_p_bz = zb_f;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p_ax  <= n_p_ax;
            r_p_ay  <= n_p_ay;
            r_p_az  <= n_p_az;
            r_p_bx  <= n_p_bx;
            r_p_by  <= n_p_by;
            r_p_bz  <= n_p_bz;
            r_p_ctl <= n_p_ctl;
        end
    end

    // ------------------------------------------------------------------
    // CORDIC chain, two lanes
    // ------------------------------------------------------------------
    logic signed [LW-1:0] w_ax [CORDIC_STAGES+1];
    logic signed [LW-1:0] w_ay [CORDIC_STAGES+1];
    logic signed [ZW-1:0] w_az [CORDIC_STAGES+1];
    logic signed [LW-1:0] w_bx [CORDIC_STAGES+1];
    logic signed [LW-1:0] w_by [CORDIC_STAGES+1];
    logic signed [ZW-1:0] w_bz [CORDIC_STAGES+1];
    csft_pkg::t_ctl       w_cctl [CORDIC_STAGES+1];

    assign w_ax[0]   = r_p_ax;
    assign w_ay[0]   = r_p_ay;
    assign w_az[0]   = r_p_az;
    assign w_bx[0]   = r_p_bx;
    assign w_by[0]   = r_p_by;
    assign w_bz[0]   = r_p_bz;
    assign w_cctl[0] = r_p_ctl;

    for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cordic
        csft_pkg::t_ctl r_ctl;

        csft_cordic_stage #(.IDX(k)) u_lane_a (
            .i_clk (i_clk),
            .i_en  (en),
            .i_rot (w_cctl[k].fwd),
            .i_x   (w_ax[k]),
            .i_y   (w_ay[k]),
            .i_z   (w_az[k]),
            .o_x   (w_ax[k+1]),
            .o_y   (w_ay[k+1]),
            .o_z   (w_az[k+1])
        );

        csft_cordic_stage #(.IDX(k)) u_lane_b (
            .i_clk (i_clk),
            .i_en  (en),
            .i_rot (w_cctl[k].fwd),
            .i_x   (w_bx[k]),
            .i_y   (w_by[k]),
            .i_z   (w_bz[k]),
            .o_x   (w_bx[k+1]),
            .o_y   (w_by[k+1]),
            .o_z   (w_bz[k+1])
        );

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_ctl <= w_cctl[k];
            end
        end

        assign w_cctl[k+1] = r_ctl;
    end

    // ------------------------------------------------------------------
    // Product stage: direction scaled by cos*cos; saturated atan2 angles
    // ------------------------------------------------------------------
    logic signed [CW-1:0]   ca;
    logic signed [CW-1:0]   sa;
    logic signed [CW-1:0]   cb;
    logic signed [CW-1:0]   sb;
    logic signed [2*CW-1:0] prod_p;
    logic signed [2*CW-1:0] prod_a;
    logic signed [2*CW-1:0] prod_b;
    logic signed [ZW-1:0]   za_end;
    logic signed [ZW-1:0]   zb_end;
    logic signed [AW-1:0]   n_m_alpha;
    logic signed [AW-1:0]   n_m_beta;
    logic signed [CW-1:0]   r_m_p;
    logic signed [CW-1:0]   r_m_a;
    logic signed [CW-1:0]   r_m_b;
    logic signed [AW-1:0]   r_m_alpha;
    logic signed [AW-1:0]   r_m_beta;
    csft_pkg::t_ctl         r_m_ctl;

    always_comb begin
        ca     = w_ax[CORDIC_STAGES][CW-1:0];
        sa     = w_ay[CORDIC_STAGES][CW-1:0];
        cb     = w_bx[CORDIC_STAGES][CW-1:0];
        sb     = w_by[CORDIC_STAGES][CW-1:0];
        prod_p = ca * cb;
        prod_a = sa * cb;
        prod_b = sb * ca;

        za_end = w_az[CORDIC_STAGES];
        zb_end = w_bz[CORDIC_STAGES];
        if (za_end > csft_pkg::PI_Q) begin
            za_end = csft_pkg::PI_Q;
        end else if (za_end < -csft_pkg::PI_Q) begin
            za_end = -csft_pkg::PI_Q;
        end
        if (zb_end > csft_pkg::PI_Q) begin
            zb_end = csft_pkg::PI_Q;
        end else if (zb_end < -csft_pkg::PI_Q) begin
            zb_end = -csft_pkg::PI_Q;
        end
        // atan2 of the origin is zero.
        n_m_alpha = w_cctl[CORDIC_STAGES].zero_a ? '0 : AW'(za_end);
        n_m_beta  = w_cctl[CORDIC_STAGES].zero_b ? '0 : AW'(zb_end);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m_p     <= CW'(prod_p >>> csft_pkg::FRAC_BITS);
            r_m_a     <= CW'(prod_a >>> csft_pkg::FRAC_BITS);
            r_m_b     <= CW'(prod_b >>> csft_pkg::FRAC_BITS);
            r_m_alpha <= n_m_alpha;
            r_m_beta  <= n_m_beta;
            r_m_ctl   <= w_cctl[CORDIC_STAGES];
        end
    end

    // ------------------------------------------------------------------
    // Face placement and squares
    // ------------------------------------------------------------------
    logic [2:0]             m_face;
    logic signed [CW-1:0]   v0;
    logic signed [CW-1:0]   v1;
    logic signed [CW-1:0]   v2;
    logic signed [2*CW-1:0] sq0;
    logic signed [2*CW-1:0] sq1;
    logic signed [2*CW-1:0] sq2;
    logic [2:0]             r_p_face;
    logic [2:0]             r_c_face [CORDIC_STAGES+1];
    csft_pkg::t_pay         r_q_pay;
    logic [SW-1:0]          r_q_sq0;
    logic [SW-1:0]          r_q_sq1;
    logic [SW-1:0]          r_q_sq2;

    // The face code rides beside the CORDIC chain for the placement step.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p_face <= i_face;
            r_c_face[0] <= r_p_face;
            for (int k = 0; k < CORDIC_STAGES; k++) begin
                r_c_face[k+1] <= r_c_face[k];
            end
        end
    end

    assign m_face = r_c_face[CORDIC_STAGES];

    always_comb begin
        case (m_face)
            csft_pkg::FACE_PX: begin
                v0 = r_m_p;  v1 = r_m_a;  v2 = r_m_b;
            end
            csft_pkg::FACE_NX: begin
                v0 = -r_m_p; v1 = -r_m_a; v2 = r_m_b;
            end
            csft_pkg::FACE_PY: begin
                v0 = -r_m_a; v1 = r_m_p;  v2 = r_m_b;
            end
            csft_pkg::FACE_NY: begin
                v0 = r_m_a;  v1 = -r_m_p; v2 = r_m_b;
            end
            csft_pkg::FACE_PZ: begin
                v0 = -r_m_b; v1 = r_m_a;  v2 = r_m_p;
            end
            default: begin
                v0 = r_m_b;  v1 = r_m_a;  v2 = -r_m_p;
            end
        endcase
        sq0 = v0 * v0;
        sq1 = v1 * v1;
        sq2 = v2 * v2;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_q_pay.ctl   <= r_m_ctl;
            r_q_pay.v0    <= v0;
            r_q_pay.v1    <= v1;
            r_q_pay.v2    <= v2;
            r_q_pay.alpha <= r_m_alpha;
            r_q_pay.beta  <= r_m_beta;
            r_q_sq0       <= sq0[SW-1:0];
            r_q_sq1       <= sq1[SW-1:0];
            r_q_sq2       <= sq2[SW-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Sum of squares
    // ------------------------------------------------------------------
    csft_pkg::t_pay r_n_pay;
    logic [SW-1:0]  r_n_n2;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_n_pay <= r_q_pay;
            r_n_n2  <= r_q_sq0 + r_q_sq1 + r_q_sq2;
        end
    end

    // ------------------------------------------------------------------
    // Integer square root, one root bit per stage
    // ------------------------------------------------------------------
    logic [SW-1:0]  w_sn   [SQ_STAGES+1];
    logic [SW-1:0]  w_sr   [SQ_STAGES+1];
    csft_pkg::t_pay w_spay [SQ_STAGES+1];

    assign w_sn[0]   = r_n_n2;
    assign w_sr[0]   = '0;
    assign w_spay[0] = r_n_pay;

    for (genvar j = 0; j < SQ_STAGES; j++) begin : g_sqrt
        csft_pkg::t_pay r_pay;

        csft_sqrt_stage #(.BIT_POS(SW - 2 - 2 * j)) u_step (
            .i_clk (i_clk),
            .i_en  (en),
            .i_n   (w_sn[j]),
            .i_r   (w_sr[j]),
            .o_n   (w_sn[j+1]),
            .o_r   (w_sr[j+1])
        );

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_pay <= w_spay[j];
            end
        end

        assign w_spay[j+1] = r_pay;
    end

    // ------------------------------------------------------------------
    // Rounded numerators |v| * 2^F + r/2
    // ------------------------------------------------------------------
    csft_pkg::t_pay       s_pay;
    logic [SW-1:0]        s_root;
    logic signed [CW-1:0] s_v [3];
    logic [CW-1:0]        mag [3];
    logic [SW-1:0]        n_d_rem [3];
    logic [SW-1:0]        r_d_rem [3];
    logic [SW-1:0]        r_d_div;
    csft_pkg::t_pay       r_d_pay;

    always_comb begin
        s_pay  = w_spay[SQ_STAGES];
        s_root = w_sr[SQ_STAGES];
        s_v[0] = s_pay.v0;
        s_v[1] = s_pay.v1;
        s_v[2] = s_pay.v2;
        for (int k = 0; k < 3; k++) begin
            mag[k]     = s_v[k][CW-1] ? CW'(-s_v[k]) : CW'(s_v[k]);
            n_d_rem[k] = (SW'(mag[k]) << csft_pkg::FRAC_BITS) + (s_root >> 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d_rem <= n_d_rem;
            r_d_div <= s_root;
            r_d_pay <= s_pay;
        end
    end

    // ------------------------------------------------------------------
    // Three restoring dividers, one quotient bit per stage
    // ------------------------------------------------------------------
    logic [SW-1:0]  w_drem [QW+1][3];
    logic [QW-1:0]  w_dq   [QW+1][3];
    logic [SW-1:0]  w_ddiv [QW+1];
    csft_pkg::t_pay w_dpay [QW+1];

    for (genvar k = 0; k < 3; k++) begin : g_div_in
        assign w_drem[0][k] = r_d_rem[k];
        assign w_dq[0][k]   = '0;
    end
    assign w_ddiv[0] = r_d_div;
    assign w_dpay[0] = r_d_pay;

    for (genvar j = 0; j < QW; j++) begin : g_div
        csft_pkg::t_pay r_pay;
        logic [SW-1:0]  r_div;

        for (genvar k = 0; k < 3; k++) begin : g_lane
            csft_div_stage #(.QBIT(QW - 1 - j)) u_step (
                .i_clk (i_clk),
                .i_en  (en),
                .i_div (w_ddiv[j]),
                .i_rem (w_drem[j][k]),
                .i_q   (w_dq[j][k]),
                .o_rem (w_drem[j+1][k]),
                .o_q   (w_dq[j+1][k])
            );
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_pay <= w_dpay[j];
                r_div <= w_ddiv[j];
            end
        end

        assign w_dpay[j+1] = r_pay;
        assign w_ddiv[j+1] = r_div;
    end

    // ------------------------------------------------------------------
    // Output register: sign, saturation and mode selection
    // ------------------------------------------------------------------
    csft_pkg::t_pay       f_pay;
    logic signed [CW-1:0] f_v [3];
    logic [QW-1:0]        qc [3];
    logic signed [XW-1:0] uv [3];
    logic                 vec_on;
    logic                 ang_on;
    logic signed [XW-1:0] r_o_x;
    logic signed [XW-1:0] r_o_y;
    logic signed [XW-1:0] r_o_z;
    logic signed [AW-1:0] r_o_alpha;
    logic signed [AW-1:0] r_o_beta;
    logic                 r_o_err;

    always_comb begin
        f_pay  = w_dpay[QW];
        f_v[0] = f_pay.v0;
        f_v[1] = f_pay.v1;
        f_v[2] = f_pay.v2;
        vec_on = f_pay.ctl.fwd && !f_pay.ctl.err && (w_ddiv[QW] != '0);
        ang_on = !f_pay.ctl.fwd && !f_pay.ctl.err;
        for (int k = 0; k < 3; k++) begin
            qc[k] = (w_dq[QW][k] > QW'(csft_pkg::ONE_Q)) ? QW'(csft_pkg::ONE_Q)
                                                         : w_dq[QW][k];
            uv[k] = XW'({1'b0, qc[k]});
            if (f_v[k][CW-1]) begin
                uv[k] = -uv[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o_x     <= vec_on ? uv[0] : '0;
            r_o_y     <= vec_on ? uv[1] : '0;
            r_o_z     <= vec_on ? uv[2] : '0;
            r_o_alpha <= ang_on ? f_pay.alpha : '0;
            r_o_beta  <= ang_on ? f_pay.beta : '0;
            r_o_err   <= f_pay.ctl.err;
        end
    end

    assign o_out_x     = r_o_x;
    assign o_out_y     = r_o_y;
    assign o_out_z     = r_o_z;
    assign o_out_alpha = r_o_alpha;
    assign o_out_beta  = r_o_beta;
    assign o_error     = r_o_err;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    logic                   chk_err;
    logic                   chk_ang;
    logic                   chk_stall;
    logic                   chk_xyz0;
    logic                   chk_zero;
    logic                   chk_bound;
    logic [3*XW+2*AW:0]     chk_res;

    // Conditions checked below, gathered to keep each check on one line.
    assign chk_err   = o_out_valid && o_error;
    assign chk_ang   = o_out_valid && ((o_out_alpha != '0) || (o_out_beta != '0));
    assign chk_stall = o_out_valid && !i_out_ready;
    assign chk_xyz0  = (o_out_x == '0) && (o_out_y == '0) && (o_out_z == '0);
    assign chk_zero  = chk_xyz0 && (o_out_alpha == '0) && (o_out_beta == '0);
    assign chk_bound = (o_out_x <= 18'sd65536) && (o_out_x >= -18'sd65536)
                    && (o_out_y <= 18'sd65536) && (o_out_y >= -18'sd65536)
                    && (o_out_z <= 18'sd65536) && (o_out_z >= -18'sd65536);
    assign chk_res   = {o_out_x, o_out_y, o_out_z, o_out_alpha, o_out_beta, o_error};

    `CSFT_ASSERT_NOW(a_err_zero, i_clk, i_rst_n, chk_err, chk_zero, "error result not zeroed")
    `CSFT_ASSERT_NOW(a_mode_excl, i_clk, i_rst_n, chk_ang, chk_xyz0 && !o_error, "mixed result")
    `CSFT_ASSERT_NOW(a_unit_bound, i_clk, i_rst_n, o_out_valid, chk_bound, "vector beyond one")
    `CSFT_ASSERT_NOW(a_ready_empty, i_clk, i_rst_n, !o_out_valid, o_in_ready, "input refused")
    `CSFT_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, chk_stall, o_out_valid && $stable(chk_res), "lost")

endmodule

`default_nettype wire
